// File: hw/rtl/bba_pkg.sv
// shared constants and field widths for the block bitmap allocator
`default_nettype none

package bba_pkg;

   localparam int DEF_MAX_BLOCKS = 4096;
   localparam int DEF_WORD_BITS  = 32;

   localparam int MODE_W  = 3;
   localparam int IDX_W   = 12;
   localparam int RUN_W   = 13;
   localparam int TOTAL_W = 13;

   localparam logic [MODE_W-1:0] MODE_SET        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TEST       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIND_FIRST = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND_RUN   = 3'd4;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

endpackage

`default_nettype wire

// File: hw/rtl/bba_if.sv
// request and response channel interfaces of the block bitmap allocator
`default_nettype none

interface bba_req_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [IDX_W-1:0]  block_index;
   logic [RUN_W-1:0]  run_length;

   modport source (output valid, output mode, output block_index, output run_length,
                   input ready);
   modport sink   (input valid, input mode, input block_index, input run_length,
                   output ready);
endinterface

interface bba_rsp_if;
   import bba_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [IDX_W-1:0] result_index;
   logic             bit_is_set;

   modport source (output valid, output found, output result_index, output bit_is_set,
                   input ready);
   modport sink   (input valid, input found, input result_index, input bit_is_set,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bba_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module bba_ram #(
   parameter int WIDTH = bba_pkg::DEF_WORD_BITS,
   parameter int DEPTH = bba_pkg::DEF_MAX_BLOCKS / bba_pkg::DEF_WORD_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bba_word_scan.sv
// one bitmap word of free-run search, carrying the run length across words
`default_nettype none

module bba_word_scan #(
   parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS,
   parameter int CNT_W     = bba_pkg::RUN_W
) (
   input  wire logic [WORD_BITS-1:0]         word_in,
   input  wire logic [CNT_W-1:0]             carry_in,
   input  wire logic [CNT_W-1:0]             want,
   output logic                              hit,
   output logic [$clog2(WORD_BITS)-1:0]      hit_pos,
   output logic [CNT_W-1:0]                  carry_out
);

   localparam int BW = $clog2(WORD_BITS);

   logic [CNT_W-1:0]     run_len [WORD_BITS];
   logic [WORD_BITS-1:0] meet;

   // free run length ending at each bit: the carry counts while no used bit has been seen
   always_comb begin
      logic [BW:0] last_used;
      for (int j = 0; j < WORD_BITS; j++) begin
         last_used = '0;
         for (int k = 0; k < WORD_BITS; k++) begin
            if (k <= j && word_in[k]) begin
               last_used = (BW+1)'(k + 1);
            end
         end
         if (word_in[j]) begin
            run_len[j] = '0;
         end else if (last_used == '0) begin
            run_len[j] = carry_in + CNT_W'(j + 1);
         end else begin
            run_len[j] = CNT_W'(j + 1) - CNT_W'(last_used);
         end
         meet[j] = !word_in[j] && (run_len[j] >= want);
      end
   end

   always_comb begin
      hit     = |meet;
      hit_pos = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (meet[j]) begin
            hit_pos = BW'(j);
         end
      end
   end

   assign carry_out = run_len[WORD_BITS-1];

endmodule

`default_nettype wire

// File: hw/rtl/block_bitmap_allocator.sv
// Block bitmap allocator: a used/free bitmap of MAX_BLOCKS blocks kept in a ram of
// WORD_BITS-bit words (1 = used), with set, clear, test, find-first-free and
// find-free-run items. After reset a clearing pass writes one word a cycle, and the
// block takes no item until every word is cleared. Set, clear and test go through
// ram read, update and result steps (the ACCESS and DONE states), and the result
// shows in the output register after DONE. A find reads one word per cycle through
// the single ram read port and a shared word-scan unit, up to the word that ends the
// run; it scans at most the managed block count over WORD_BITS words. An item that
// reads no word (block out of range, unused mode, empty search range, zero run) goes
// from accept straight to DONE. One item is in work at a time; a result waits in the
// output register while the next item is accepted, and a result not yet taken holds
// the next item at its end.
`default_nettype none

module block_bitmap_allocator #(
   parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   bba_req_if.sink                           req_chan,
   bba_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_wr_en,
   input  wire logic [bba_pkg::TOTAL_W-1:0]  csr_wr_data
);
   import bba_pkg::*;

   // word_bits must be a power of two
   localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BW         = $clog2(WORD_BITS);
   localparam int CNT_W      = ($clog2(MAX_BLOCKS) + 1 > RUN_W) ?
                               $clog2(MAX_BLOCKS) + 1 : RUN_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [BW-1:0]      bitpos_ff, bitpos_in;
   logic [CNT_W-1:0]   want_ff, want_in;
   logic [AW-1:0]      word_ff, word_in;
   logic [AW-1:0]      last_word_ff, last_word_in;
   logic [CNT_W-1:0]   carry_ff, carry_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   logic               bit_ff, bit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic               rsp_bit_ff, rsp_bit_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   logic                 scan_hit;
   logic [BW-1:0]        scan_pos;
   logic [CNT_W-1:0]     scan_carry;

   logic [CNT_W-1:0]     blk_ext;
   logic [CNT_W-1:0]     total_lim;
   logic [CNT_W-1:0]     word_total;
   logic [AW-1:0]        blk_word;
   logic                 blk_ok;
   logic                 is_access;
   logic                 accept;
   logic                 out_free;
   logic [CNT_W-1:0]     end_pos;
   logic [CNT_W-1:0]     start_pos;
   logic [WORD_BITS-1:0] bit_mask;

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bba_word_scan #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W)
   ) u_scan (
      .word_in   (ram_rdata),
      .carry_in  (carry_ff),
      .want      (want_ff),
      .hit       (scan_hit),
      .hit_pos   (scan_pos),
      .carry_out (scan_carry)
   );

   assign accept   = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // searched words come from the block count capped at the store size
   assign blk_ext    = CNT_W'(req_chan.block_index);
   assign blk_ok     = blk_ext < CNT_W'(MAX_BLOCKS);
   assign blk_word   = AW'(blk_ext >> BW);
   assign total_lim  = (CNT_W'(total_ff) > CNT_W'(MAX_BLOCKS)) ?
                       CNT_W'(MAX_BLOCKS) : CNT_W'(total_ff);
   assign word_total = total_lim >> BW;
   assign is_access  = (req_chan.mode == MODE_SET) || (req_chan.mode == MODE_CLEAR) ||
                       (req_chan.mode == MODE_TEST);

   assign end_pos   = (CNT_W'(word_ff) << BW) | CNT_W'(scan_pos);
   assign start_pos = end_pos + CNT_W'(1) - want_ff;
   assign bit_mask  = WORD_BITS'(1) << bitpos_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      mode_in      = mode_ff;
      bitpos_in    = bitpos_ff;
      want_in      = want_ff;
      word_in      = word_ff;
      last_word_in = last_word_ff;
      carry_in     = carry_ff;
      found_in     = found_ff;
      index_in     = index_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_bit_in   = rsp_bit_ff;
      ram_we       = 1'b0;
      ram_waddr    = word_ff;
      ram_wdata    = ram_rdata;
      // during a scan the next word is read while this one is checked
      ram_raddr    = word_ff + AW'(1);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_raddr = is_access ? blk_word : '0;
            if (accept) begin
               mode_in      = req_chan.mode;
               bitpos_in    = req_chan.block_index[BW-1:0];
               want_in      = CNT_W'(req_chan.run_length);
               word_in      = '0;
               last_word_in = AW'(word_total - CNT_W'(1));
               carry_in     = '0;
               found_in     = 1'b0;
               index_in     = '0;
               bit_in       = 1'b0;
               state_in     = ST_DONE;
               case (req_chan.mode)
                  MODE_SET, MODE_CLEAR, MODE_TEST: begin
                     if (blk_ok) begin
                        word_in  = blk_word;
                        state_in = ST_ACCESS;
                     end
                  end
                  MODE_FIND_FIRST: begin
                     // lowest free block is a free run of one
                     want_in = CNT_W'(1);
                     if (word_total != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_FIND_RUN: begin
                     if (req_chan.run_length != '0 && word_total != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            case (mode_ff)
               MODE_SET: begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata | bit_mask;
               end
               MODE_CLEAR: begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata & ~bit_mask;
               end
               default: begin
                  bit_in = ram_rdata[bitpos_ff];
               end
            endcase
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               found_in = 1'b1;
               index_in = start_pos[IDX_W-1:0];
               state_in = ST_DONE;
            end else if (word_ff == last_word_ff) begin
               state_in = ST_DONE;
            end else begin
               word_in  = word_ff + AW'(1);
               carry_in = scan_carry;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_index_in = index_ff;
               rsp_bit_in   = bit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         total_ff     <= TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
      end
      mode_ff      <= mode_in;
      bitpos_ff    <= bitpos_in;
      want_ff      <= want_in;
      word_ff      <= word_in;
      last_word_ff <= last_word_in;
      carry_ff     <= carry_in;
      found_ff     <= found_in;
      index_ff     <= index_in;
      bit_ff       <= bit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_bit_ff   <= rsp_bit_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = rsp_found_ff;
   assign rsp_chan.result_index = rsp_index_ff;
   assign rsp_chan.bit_is_set   = rsp_bit_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bba_checker.sv
// port-level assertions for the block bitmap allocator and their bind
`default_nettype none

module bba_checker (
   input wire logic  clock,
   input wire logic  reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan
);

   // no result is left over from before reset
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   // an accepted item keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("ready again right after an accepted item");

   // a miss or a non-find item reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |-> (rsp_chan.result_index == '0))
      else $error("nonzero index without a find");

   // a test result never also claims a find
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.bit_is_set) |-> !rsp_chan.found)
      else $error("bit_is_set and found together");

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
      (rsp_chan.valid && $stable(rsp_chan.found) && $stable(rsp_chan.result_index) &&
       $stable(rsp_chan.bit_is_set)))
      else $error("result dropped or changed while stalled");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

`default_nettype wire
